### src/page_allocator_with_refcounts_macros.svh
// Assertion helpers used by the allocator back end.
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNTS_MACROS_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNTS_MACROS_SVH

// Checks that a condition implies a property in the same cycle.
`define PA_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Checks that a condition implies a property in the next cycle.
`define PA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

### src/pa_pkg.sv
package pa_pkg;
  localparam int NumPages = 32768;
  localparam int PageShift = 12;
  localparam int CountBits = 8;
  localparam int AddrBits = 56;
  localparam int IdxBits = $clog2(NumPages);
  localparam int TopBits = $clog2(NumPages + 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE = 2'd1,
    OP_ADDREF = 2'd2,
    OP_GETREF = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_OOM = 3'd1,
    ST_BAD_ADDR = 3'd2,
    ST_SATURATED = 3'd3,
    ST_STACK_FULL = 3'd4
  } status_t;

  localparam logic CFG_LOWEST = 1'b0;
  localparam logic CFG_STOP = 1'b1;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    op_t op;
    logic bad;
    logic [IdxBits-1:0] idx;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_CLEAR
  } bk_state_t;
endpackage

### src/pa_front.sv
module pa_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] op,
  input  logic [pa_pkg::AddrBits-1:0] addr,
  input  logic [pa_pkg::AddrBits-1:0] base,
  input  logic [pa_pkg::AddrBits-1:0] lowest_addr,
  input  logic [pa_pkg::AddrBits-1:0] stop_addr,
  output logic q_valid,
  input  logic q_ready,
  output pa_pkg::req_t q_req
);
  import pa_pkg::*;

  localparam int OffBits = AddrBits - PageShift;

  logic [AddrBits-1:0] diff;
  logic [OffBits-1:0] pnum;
  logic valid_addr;
  logic full;
  req_t req_next;

  assign diff = addr - base;
  assign pnum = diff[AddrBits-1:PageShift];
  // Page numbers beyond the managed count have a high bit set above the index.
  assign valid_addr = (addr[PageShift-1:0] == '0) && (addr >= lowest_addr) &&
                      (addr < stop_addr) && (addr >= base) &&
                      (pnum < OffBits'(NumPages));

  always_comb begin
    req_next.op = op_t'(op);
    req_next.bad = (op_t'(op) != OP_ALLOC) && !valid_addr;
    req_next.idx = pnum[IdxBits-1:0];
  end

  // One-entry queue register.
  assign full = q_valid;
  assign in_ready = !full || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (q_ready) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_req <= req_next;
    end
  end
endmodule

### src/pa_back.sv
module pa_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  pa_pkg::req_t q_req,
  input  logic [pa_pkg::AddrBits-1:0] base,
  output logic busy,
  output logic out_valid,
  input  logic out_ready,
  output logic [pa_pkg::AddrBits-1:0] page_addr,
  output logic [7:0] ref_count,
  output logic released,
  output logic [2:0] status
);
  import pa_pkg::*;
  `include "page_allocator_with_refcounts_macros.svh"

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [CountBits-1:0] CountOne = CountBits'(1);

  bk_state_t state, state_next;
  req_t cur;
  logic [TopBits-1:0] free_top, free_top_next;
  logic [IdxBits-1:0] stack_mem [NumPages];
  logic [CountBits-1:0] count_mem [NumPages];
  logic [IdxBits-1:0] clr_idx;
  logic [IdxBits-1:0] stack_rd;
  logic [CountBits-1:0] count_rd;
  logic [CountBits-1:0] cnt;
  logic [IdxBits-1:0] pop_idx;

  logic cnt_we, stk_we;
  logic [CountBits-1:0] cnt_wdata;
  logic [IdxBits-1:0] cnt_waddr;
  logic [AddrBits-1:0] res_addr;
  logic [CountBits-1:0] res_count;
  logic res_rel;
  status_t res_status;
  logic load_cur, start_read, do_exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_READ;
      BK_READ: state_next = BK_EXEC;
      BK_EXEC: if (!out_valid || out_ready) state_next = BK_IDLE;
      BK_CLEAR: if (clr_idx == IdxBits'(NumPages - 1)) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == BK_IDLE);
    load_cur = (state == BK_IDLE) && q_valid;
    start_read = (state == BK_READ);
    do_exec = (state == BK_EXEC) && (!out_valid || out_ready);
    busy = (state != BK_IDLE) || q_valid;
  end

  // After reset every count entry is zeroed, one per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == BK_CLEAR) begin
      clr_idx <= clr_idx + IdxBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur <= q_req;
    end
  end

  // The popped entry lives one below the top; a pop reads it here.
  always_ff @(posedge clk) begin
    if (start_read) begin
      stack_rd <= stack_mem[IdxBits'(free_top - TopBits'(1))];
    end
  end
  always_ff @(posedge clk) begin
    if (start_read) begin
      count_rd <= count_mem[cur.idx];
    end
  end
  assign cnt = count_rd;
  assign pop_idx = stack_rd;

  always_comb begin
    res_addr = '0;
    res_count = '0;
    res_rel = 1'b0;
    res_status = ST_OK;
    cnt_we = 1'b0;
    stk_we = 1'b0;
    cnt_waddr = cur.idx;
    cnt_wdata = '0;
    free_top_next = free_top;
    if (cur.op == OP_ALLOC) begin
      if (free_top == '0) begin
        res_status = ST_OOM;
      end else begin
        free_top_next = free_top - TopBits'(1);
        cnt_we = 1'b1;
        cnt_waddr = pop_idx;
        cnt_wdata = CountOne;
        res_count = CountOne;
        res_addr = base + (AddrBits'(pop_idx) << PageShift);
      end
    end else if (cur.bad) begin
      res_status = ST_BAD_ADDR;
    end else begin
      unique case (cur.op)
        OP_FREE: begin
          if (cnt > CountOne) begin
            cnt_we = 1'b1;
            cnt_wdata = cnt - CountOne;
            res_count = cnt - CountOne;
          end else if (free_top >= TopBits'(NumPages)) begin
            res_count = cnt;
            res_status = ST_STACK_FULL;
          end else begin
            stk_we = 1'b1;
            free_top_next = free_top + TopBits'(1);
            res_count = cnt;
            res_rel = 1'b1;
          end
        end
        OP_ADDREF: begin
          if (cnt == CountMax) begin
            res_count = cnt;
            res_status = ST_SATURATED;
          end else begin
            cnt_we = 1'b1;
            cnt_wdata = cnt + CountOne;
            res_count = cnt + CountOne;
          end
        end
        default: res_count = cnt;
      endcase
    end
    if (!do_exec) begin
      cnt_we = 1'b0;
      stk_we = 1'b0;
      free_top_next = free_top;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) count_mem[clr_idx] <= '0;
    else if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
  end
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[free_top[IdxBits-1:0]] <= cur.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0;
      out_valid <= 1'b0;
    end else begin
      free_top <= free_top_next;
      if (do_exec) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec) begin
      page_addr <= res_addr;
      ref_count <= 8'(res_count);
      released <= res_rel;
      status <= res_status;
    end
  end

  `PA_ASSERT_IMP(a_top_range, 1'b1, free_top <= TopBits'(NumPages))
  `PA_ASSERT_NEXT(a_read_then_exec, state == BK_READ, state == BK_EXEC)
  `PA_ASSERT_IMP(a_one_write, stk_we, !cnt_we)
  `PA_ASSERT_NEXT(a_push_grows, stk_we, free_top == $past(free_top) + TopBits'(1))
endmodule

### src/page_allocator_with_refcounts.sv
// Page allocator with a LIFO free stack and per-page 8-bit reference counts
// over 32768 pages of 4 KiB. The back end handles each item in turn (queue
// pop, registered memory read, execute and write) and takes no new item until
// the current one is done; a single-entry queue lets the next item be
// classified while the current one runs. After reset the back end zeroes
// the count memory and takes no item until that is done; the free stack
// starts empty, so software frees each page once to populate it. The address
// registers accept writes only while the block is idle (cfg_ready is low
// otherwise).
module page_allocator_with_refcounts (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] op,
  input  logic [55:0] addr,
  output logic out_valid,
  input  logic out_ready,
  output logic [55:0] page_addr,
  output logic [7:0] ref_count,
  output logic released,
  output logic [2:0] status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [55:0] cfg_data
);
  import pa_pkg::*;

  localparam logic [AddrBits-1:0] PageMask = AddrBits'((64'd1 << PageShift) - 64'd1);

  logic [AddrBits-1:0] lowest_addr, stop_addr, base;
  logic q_valid, q_ready, busy;
  req_t q_req;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_addr <= AddrBits'(64'h8000_0000);
      stop_addr <= AddrBits'(64'h8800_0000);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LOWEST) lowest_addr <= cfg_data;
      else stop_addr <= cfg_data;
    end
  end
  assign base = (lowest_addr + PageMask) & ~PageMask;

  pa_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .addr, .base, .lowest_addr,
    .stop_addr, .q_valid, .q_ready, .q_req
  );

  pa_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req, .base, .busy, .out_valid,
    .out_ready, .page_addr, .ref_count, .released, .status
  );
endmodule
